FILE: rtl/core/ile_pkg.sv
// Shared types and codes for the indexed list engine.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;

  // Operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_INSERT_AT  = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_BACK   = 3'd4,
    KIND_REMOVE_AT  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  // What every cell of a chain does with its stored value
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    value;
  } chain_ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    data_t             value;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    data_t              removed_value;
    logic               removed_valid;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
    data_t              front_value;
    data_t              back_value;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/indexed_list_engine.sv
// Top level of the indexed list engine: control, count and result register.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values. Each input
// beat on in_data asks for push front, push back, insert at a position, pop
// front, pop back or remove at a position. Each beat yields exactly one
// result beat on out_data with the removed value, a status code and the
// count, front and back of the list after the operation.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while out_ready is high, as every cell of the chains
// shifts, loads or holds on the edge that accepts the item.
// in_ready is high while the result register is empty or being drained, so
// a stalled receiver holds the current result and stops new input until the
// result beat is taken.
// Reset clears the entry count and the result valid flag; list storage is
// not cleared, as only entries below the count are ever read.
// Two chains are kept: one in list order and one in reverse order, so that
// both the front and the back sit in the first cell of a chain.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine #(
  parameter int CAPACITY = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ile_pkg::item_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ile_pkg::result_t      out_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

  logic                      in_fire;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [CMPW-1:0]           count_ext;
  logic [CMPW-1:0]           pos_ext;
  logic                      is_full;
  logic                      is_empty;
  logic                      do_ins;
  logic                      do_rem;
  logic                      use_rev;
  logic [IW-1:0]             fwd_idx;
  logic [IW-1:0]             rev_idx;
  logic [ile_pkg::POS_W-1:0] fwd_peek_pos;
  ile_pkg::status_t          status;
  ile_pkg::cell_op_t         op;
  ile_pkg::chain_ctl_t       ctl;
  ile_pkg::data_t            fwd_head_next;
  ile_pkg::data_t            rev_head_next;
  ile_pkg::data_t            fwd_peek;
  ile_pkg::data_t            rev_peek;
  ile_pkg::result_t          res;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign count_ext = CMPW'(count);
  assign pos_ext   = CMPW'(in_data.position);
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);

  // Decode the operation into a chain index in list order
  always_comb begin
    status       = ile_pkg::ST_OK;
    do_ins       = 1'b0;
    do_rem       = 1'b0;
    use_rev      = 1'b0;
    fwd_idx      = '0;
    fwd_peek_pos = in_data.position;
    case (in_data.kind)
      ile_pkg::KIND_PUSH_FRONT: begin
        if (is_full) begin
          status = ile_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ile_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          status = ile_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          fwd_idx = IW'(count);
        end
      end
      ile_pkg::KIND_INSERT_AT: begin
        if (is_full) begin
          status = ile_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          // past the end appends
          if (pos_ext > count_ext) begin
            fwd_idx = IW'(count);
          end else begin
            fwd_idx = IW'(in_data.position);
          end
        end
      end
      ile_pkg::KIND_POP_FRONT: begin
        fwd_peek_pos = '0;
        if (is_empty) begin
          status = ile_pkg::ST_EMPTY;
        end else begin
          do_rem = 1'b1;
        end
      end
      ile_pkg::KIND_POP_BACK: begin
        use_rev = 1'b1;
        if (is_empty) begin
          status = ile_pkg::ST_EMPTY;
        end else begin
          do_rem  = 1'b1;
          fwd_idx = IW'(count - CW'(1));
        end
      end
      ile_pkg::KIND_REMOVE_AT: begin
        if (is_empty) begin
          status = ile_pkg::ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          status = ile_pkg::ST_PAST_END;
        end else begin
          do_rem  = 1'b1;
          fwd_idx = IW'(in_data.position);
        end
      end
      default: begin
        status = ile_pkg::ST_OK;
      end
    endcase
  end

  // Mirror the index into the reversed chain and build the cell command
  always_comb begin
    op         = ile_pkg::CELL_HOLD;
    rev_idx    = '0;
    count_next = count;
    if (do_ins) begin
      op         = ile_pkg::CELL_INSERT;
      rev_idx    = IW'(count - CW'(fwd_idx));
      count_next = count + CW'(1);
    end else if (do_rem) begin
      op         = ile_pkg::CELL_REMOVE;
      rev_idx    = IW'(count - CW'(1) - CW'(fwd_idx));
      count_next = count - CW'(1);
    end
    ctl.op    = in_fire ? op : ile_pkg::CELL_HOLD;
    ctl.value = in_data.value;
  end

  ile_chain #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_fwd (
    .clk       (clk),
    .ctl       (ctl),
    .index     (fwd_idx),
    .peek_pos  (fwd_peek_pos),
    .head_next (fwd_head_next),
    .peek_data (fwd_peek)
  );

  ile_chain #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_rev (
    .clk       (clk),
    .ctl       (ctl),
    .index     (rev_idx),
    .peek_pos  ('0),
    .head_next (rev_head_next),
    .peek_data (rev_peek)
  );

  // Result fields for this beat
  always_comb begin
    res.removed_valid = do_rem;
    res.removed_value = do_rem ? (use_rev ? rev_peek : fwd_peek) : '0;
    res.status        = status;
    res.entry_count   = ile_pkg::COUNT_W'(count_next);
    res.front_value   = (count_next == '0) ? '0 : fwd_head_next;
    res.back_value    = (count_next == '0) ? '0 : rev_head_next;
  end

  // Count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

  // A rejected insert leaves the count alone
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res.status == ile_pkg::ST_FULL) |=> count == $past(count))
    else $error("count changed on a full list");

  // A removal drops the count by one
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res.removed_valid) |=> count == $past(count) - CW'(1))
    else $error("removal did not decrement count");

  // A removed entry always reports success
  a_remove_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.removed_valid) |-> out_data.status == ile_pkg::ST_OK)
    else $error("removed entry with non-ok status");

  // The list never grows past its capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

endmodule

`default_nettype wire

FILE: rtl/core/ile_cell.sv
// One storage cell of the list chain: holds, loads, or takes a neighbor.
`timescale 1ns / 1ps
`default_nettype none

module ile_cell #(
  parameter int IW  = 4,
  parameter int POS = 0
) (
  input  wire logic               clk,
  input  wire ile_pkg::chain_ctl_t ctl,
  input  wire logic [IW-1:0]      index,
  input  wire ile_pkg::data_t     left_data,
  input  wire ile_pkg::data_t     right_data,
  output ile_pkg::data_t          data,
  output ile_pkg::data_t          data_next
);

  localparam logic [IW-1:0] MY_POS = IW'(POS);

  // Insert opens a gap at index, remove closes it
  always_comb begin
    data_next = data;
    case (ctl.op)
      ile_pkg::CELL_INSERT: begin
        if (MY_POS > index) begin
          data_next = left_data;
        end else if (MY_POS == index) begin
          data_next = ctl.value;
        end
      end
      ile_pkg::CELL_REMOVE: begin
        if (MY_POS >= index) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ile_chain.sv
// Row of list cells with head lookahead and a short random-access peek.
`timescale 1ns / 1ps
`default_nettype none

module ile_chain #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic                      clk,
  input  wire ile_pkg::chain_ctl_t       ctl,
  input  wire logic [IW-1:0]             index,
  input  wire logic [ile_pkg::POS_W-1:0] peek_pos,
  output ile_pkg::data_t                 head_next,
  output ile_pkg::data_t                 peek_data
);

  localparam int PEEK_SPAN = 1 << ile_pkg::POS_W;
  localparam int PEEK_N    = (DEPTH < PEEK_SPAN) ? DEPTH : PEEK_SPAN;

  ile_pkg::data_t cells [DEPTH];
  ile_pkg::data_t cells_next [DEPTH];

  // Cells pass data to neighbors; the last cell takes its own value on remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ile_pkg::data_t left_in;
    ile_pkg::data_t right_in;

    if (i == 0) begin : g_first
      assign left_in = cells[i];
    end else begin : g_mid_l
      assign left_in = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = cells[i];
    end else begin : g_mid_r
      assign right_in = cells[i+1];
    end

    ile_cell #(
      .IW  (IW),
      .POS (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .index      (index),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cells[i]),
      .data_next  (cells_next[i])
    );
  end

  assign head_next = cells_next[0];

  // Peek reaches only the positions the position field can name
  always_comb begin
    peek_data = '0;
    for (int i = 0; i < PEEK_N; i++) begin
      if (peek_pos == ile_pkg::POS_W'(i)) begin
        peek_data = cells[i];
      end
    end
  end

endmodule

`default_nettype wire
